// ===== rtl/core/shell_quote_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef SHELL_QUOTE_TOKENIZER_MACROS_SVH
`define SHELL_QUOTE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SQT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SQT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sqt_pkg.sv =====
// Shared types and constants for the shell quote tokenizer.
// Used by every module under rtl/core; depends on nothing.
package sqt_pkg;

	// Argument list capacity, clipped to what a 7-bit count holds
	localparam int MAX_ARGS    = 64;
	localparam int CAPACITY    = (MAX_ARGS < 127) ? MAX_ARGS : 127;
	localparam int MAX_RESULTS = 3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic {
		CMD_CHAR = 1'b0,
		CMD_EOL  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic [6:0] word_count;
		logic       overflow;
		logic       last_of_run;
	} out_item_t;

	// Results caused by one input item, oldest in slot 0
	typedef struct packed {
		logic [1:0]                        cnt;
		out_item_t [MAX_RESULTS-1:0]       res;
	} bundle_t;

	typedef struct packed {
		logic       inside_word;
		logic       single_quoted;
		logic       double_quoted;
		logic       escape_in_double;
		logic       escape_plain;
		logic       word_has_chars;
		logic       list_closed;
		logic [6:0] words_seen;
		logic       words_dropped;
	} tok_state_t;

endpackage

// ===== rtl/core/sqt_front.sv =====
// Front end: accepts characters, tracks quoting state, builds result bundles.
// Depends on sqt_pkg.
module sqt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  sqt_pkg::in_item_t item,
	output logic             q_wr,
	output sqt_pkg::bundle_t q_data,
	input  logic             q_full
);
	import sqt_pkg::*;

	localparam logic [6:0] CAP7 = 7'(CAPACITY);

	tok_state_t state_q;
	tok_state_t st;
	bundle_t    b;
	logic       done;
	logic       accept;

	function automatic void add_result(inout bundle_t bb, input out_item_t r);
		bb.res[bb.cnt] = r;
		bb.cnt         = bb.cnt + 2'd1;
	endfunction

	function automatic void emit_char(inout tok_state_t s, inout bundle_t bb,
		input logic [7:0] c);
		out_item_t r;
		r = '0;
		if (!s.word_has_chars) begin
			s.word_has_chars = 1'b1;
			if (!s.list_closed && !s.words_dropped) begin
				if (s.words_seen >= CAP7)
					s.words_dropped = 1'b1;
				else
					s.words_seen = s.words_seen + 7'd1;
			end
		end
		if (!s.list_closed && !s.words_dropped) begin
			r.kind       = KIND_CHAR;
			r.char_value = c;
			add_result(bb, r);
		end
	endfunction

	function automatic void end_word(inout tok_state_t s, inout bundle_t bb);
		out_item_t r;
		r = '0;
		if (s.word_has_chars) begin
			if (!s.list_closed && !s.words_dropped) begin
				r.kind = KIND_WORD_END;
				add_result(bb, r);
			end
		end else begin
			s.list_closed = 1'b1;
		end
		s.inside_word    = 1'b0;
		s.word_has_chars = 1'b0;
	endfunction

	// Classify the incoming item and collect its results
	always_comb begin
		out_item_t r;
		st   = state_q;
		b    = '0;
		done = 1'b0;
		r    = '0;
		if (item.cmd == CMD_EOL) begin
			if (st.escape_in_double)
				emit_char(st, b, CH_BSLASH);
			if (st.inside_word && st.word_has_chars)
				end_word(st, b);
			r.kind       = KIND_LINE_END;
			r.word_count = st.words_seen;
			r.overflow   = st.words_dropped;
			add_result(b, r);
			st = '0;
		end else if (item.char_code != CH_NUL) begin
			if (st.escape_plain) begin
				st.escape_plain = 1'b0;
				emit_char(st, b, item.char_code);
				done = 1'b1;
			end else if (st.escape_in_double) begin
				st.escape_in_double = 1'b0;
				if (item.char_code == CH_DQUOTE || item.char_code == CH_BSLASH) begin
					emit_char(st, b, item.char_code);
					done = 1'b1;
				end else begin
					emit_char(st, b, CH_BSLASH);
				end
			end
			if (!done) begin
				if (item.char_code == CH_SPACE && !st.single_quoted && !st.double_quoted) begin
					if (st.inside_word)
						end_word(st, b);
				end else begin
					st.inside_word = 1'b1;
					if (item.char_code == CH_SQUOTE && !st.double_quoted)
						st.single_quoted = ~st.single_quoted;
					else if (item.char_code == CH_DQUOTE && !st.single_quoted)
						st.double_quoted = ~st.double_quoted;
					else if (item.char_code == CH_BSLASH && st.double_quoted)
						st.escape_in_double = 1'b1;
					else if (item.char_code == CH_BSLASH && !st.single_quoted)
						st.escape_plain = 1'b1;
					else
						emit_char(st, b, item.char_code);
				end
			end
		end
		// Mark the final result of this transaction
		if (b.cnt != 2'd0)
			b.res[b.cnt - 2'd1].last_of_run = 1'b1;
	end

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_wr   = accept && (b.cnt != 2'd0);
	assign q_data = b;

	// Advance the quoting state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= st;
		end
	end

endmodule

// ===== rtl/core/sqt_queue.sv =====
// Bundle queue between the front end and the result serializer.
// Depends on sqt_pkg and shell_quote_tokenizer_macros.svh.
`include "shell_quote_tokenizer_macros.svh"

module sqt_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  sqt_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd,
	output sqt_pkg::bundle_t rd_data,
	output logic             valid
);
	import sqt_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	bundle_t          mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign wr_en   = wr && !full;
	assign rd_en   = rd && valid;
	assign rd_data = mem[rd_ptr_q];

	// Store bundles
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CNT_W'(1);
		end
	end

	`SQT_ASSERT_NOW(a_no_empty_bundle, clk, arst_n, wr_en, wr_data.cnt != 2'd0, "empty bundle queued")
	`SQT_ASSERT_NOW(a_no_overread, clk, arst_n, rd, valid, "read from empty bundle queue")
	`SQT_ASSERT_NEXT(a_count_tracks, clk, arst_n, wr_en && !rd_en, count_q != '0, "count lost a write")

endmodule

// ===== rtl/core/sqt_back.sv =====
// Back end: unpacks bundles into single results held in an output register.
// Depends on sqt_pkg and shell_quote_tokenizer_macros.svh.
`include "shell_quote_tokenizer_macros.svh"

module sqt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sqt_pkg::bundle_t  q_data,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output sqt_pkg::out_item_t token
);
	import sqt_pkg::*;

	logic       out_valid_q;
	out_item_t  out_q;
	logic [1:0] idx_q;
	logic       load;
	logic       last_slot;

	assign load      = q_valid && (!out_valid_q || pop);
	assign last_slot = (idx_q == q_data.cnt - 2'd1);
	assign q_rd      = load && last_slot;
	assign empty     = !out_valid_q;
	assign token     = out_q;

	// Hold the current result until it is taken
	always_ff @(posedge clk) begin
		if (load)
			out_q <= q_data.res[idx_q];
	end

	// Step through the slots of the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= last_slot ? 2'd0 : idx_q + 2'd1;
		end
	end

	`SQT_ASSERT_NOW(a_idx_in_bundle, clk, arst_n, q_valid, idx_q < q_data.cnt, "slot index past bundle")
	`SQT_ASSERT_NOW(a_last_closes, clk, arst_n, q_rd, q_data.res[idx_q].last_of_run, "bundle retired before its last result")
	`SQT_ASSERT_NOW(a_eol_last, clk, arst_n, out_valid_q && out_q.kind == KIND_LINE_END, out_q.last_of_run, "line end not last of its transaction")

endmodule

// ===== rtl/core/shell_quote_tokenizer.sv =====
// Top level of the shell quote tokenizer: front end, bundle queue, serializer.
// Depends on sqt_pkg, sqt_front, sqt_queue and sqt_back.
//
//   Channel   Handshake        Payload
//   input     push / full      item  (sqt_pkg::in_item_t: cmd, char_code)
//   result    empty / pop      token (sqt_pkg::out_item_t: kind, char_value,
//                                     word_count, overflow, last_of_run)
//
// One input transaction per cycle while the bundle queue has room.
// The serializer sends one result per cycle while popped; an item's results go in turn.
// First result reaches the ports through the bundle queue and the output register.
// QUEUE_DEPTH bundles absorb bursts; full rises only when the queue fills.
// Reset clears the quoting state, queue pointers and output valid.
module shell_quote_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sqt_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output sqt_pkg::out_item_t token
);
	import sqt_pkg::*;

	logic    q_wr;
	bundle_t q_wr_data;
	logic    q_full;
	logic    q_rd;
	bundle_t q_rd_data;
	logic    q_valid;

	// Classify characters and build bundles
	sqt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_wr   (q_wr),
		.q_data (q_wr_data),
		.q_full (q_full)
	);

	// Decouple front end from result delivery
	sqt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.valid   (q_valid)
	);

	// Send results one at a time
	sqt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rd_data),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.token   (token)
	);

endmodule

// ===== sim/tb_shell_quote_tokenizer.sv =====
// Self-checking testbench for shell_quote_tokenizer: directed and random command lines.
// Predicts every token with its own word-splitting model and checks the results in order.
// Depends on sqt_pkg and the shell_quote_tokenizer RTL.
`timescale 1ns / 100ps

module tb_shell_quote_tokenizer;
	import sqt_pkg::*;

	localparam int ARG_LIMIT   = (MAX_ARGS < 127) ? MAX_ARGS : 127;
	localparam int TAIL_CYCLES = 8;

	// Word-splitting predictor and the queue of tokens it still expects
	class word_splitter;
		bit        in_word, in_squote, in_dquote, esc_dquote, esc_plain;
		bit        has_chars, closed, dropped;
		bit [6:0]  nwords;
		out_item_t pending[$];
		out_item_t run[$];
		int        mismatches;

		function void clear();
			in_word = 0; in_squote = 0; in_dquote = 0; esc_dquote = 0;
			esc_plain = 0; has_chars = 0; closed = 0; dropped = 0; nwords = '0;
		endfunction

		function bit listed();
			return !closed && !dropped;
		endfunction

		function void add(kind_t k, logic [7:0] ch, logic [6:0] cnt, logic ovf);
			out_item_t t;
			t.kind        = k;
			t.char_value  = ch;
			t.word_count  = cnt;
			t.overflow    = ovf;
			t.last_of_run = 1'b0;
			run.push_back(t);
		endfunction

		// Count a new word on its first character; drop words past capacity
		function void emit(logic [7:0] ch);
			if (!has_chars) begin
				has_chars = 1;
				if (listed()) begin
					if (nwords >= ARG_LIMIT)
						dropped = 1;
					else
						nwords++;
				end
			end
			if (listed())
				add(KIND_CHAR, ch, '0, 1'b0);
		endfunction

		// An empty word closes the argument list
		function void close_word();
			if (has_chars) begin
				if (listed())
					add(KIND_WORD_END, '0, '0, 1'b0);
			end else begin
				closed = 1;
			end
			in_word = 0;
			has_chars = 0;
		endfunction

		// Note an accepted input transaction and queue the tokens it causes
		function void note_item(in_item_t it);
			out_item_t  t;
			logic [7:0] c;
			bit         taken;
			c = it.char_code;
			run.delete();
			if (it.cmd == CMD_EOL) begin
				if (esc_dquote)
					emit(CH_BSLASH);
				if (in_word && has_chars)
					close_word();
				add(KIND_LINE_END, '0, nwords, dropped);
				clear();
			end else if (c != CH_NUL) begin
				taken = 0;
				if (esc_plain) begin
					esc_plain = 0;
					emit(c);
					taken = 1;
				end else if (esc_dquote) begin
					esc_dquote = 0;
					if (c == CH_DQUOTE || c == CH_BSLASH) begin
						emit(c);
						taken = 1;
					end else begin
						emit(CH_BSLASH);
					end
				end
				if (!taken) begin
					if (c == CH_SPACE && !in_squote && !in_dquote) begin
						if (in_word)
							close_word();
					end else begin
						in_word = 1;
						if (c == CH_SQUOTE && !in_dquote)
							in_squote = !in_squote;
						else if (c == CH_DQUOTE && !in_squote)
							in_dquote = !in_dquote;
						else if (c == CH_BSLASH && in_dquote)
							esc_dquote = 1;
						else if (c == CH_BSLASH && !in_squote)
							esc_plain = 1;
						else
							emit(c);
					end
				end
			end
			for (int i = 0; i < run.size(); i++) begin
				t = run[i];
				t.last_of_run = (i == run.size() - 1);
				pending.push_back(t);
			end
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare an accepted result transaction with the oldest expected token
		function void match_token(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected token: kind %0d, char_value %0h", got.kind, got.char_value);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			check_field("kind", 8'(want.kind), 8'(got.kind));
			check_field("char_value", want.char_value, got.char_value);
			check_field("word_count", 8'(want.word_count), 8'(got.word_count));
			check_field("overflow", 8'(want.overflow), 8'(got.overflow));
			check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t token;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;

	word_splitter sb = new;

	shell_quote_tokenizer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.token (token)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: pop at random per the current idle rate
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result transaction mid-cycle, before the edge that accepts it
	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			sb.match_token(token);
	end

	// Drive one input transaction; hold push high afterwards for back-to-back items
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(negedge clk);
		while (full) begin
			@(posedge clk);
			@(negedge clk);
		end
		sb.note_item(it);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] c);
		in_item_t it;
		it.cmd = CMD_CHAR;
		it.char_code = c;
		send_item(it);
	endtask

	task automatic send_eol();
		in_item_t it;
		it.cmd = CMD_EOL;
		it.char_code = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Any byte that carries no quoting or splitting meaning
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_SPACE || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
		return c;
	endfunction

	// Hold off input until every expected token has come, then let the pipe settle
	task automatic drain();
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One word built from plain, quoted and escaped segments
	task automatic send_word();
		int nseg, nch;
		nseg = $urandom_range(1, 3);
		for (int s = 0; s < nseg; s++) begin
			nch = $urandom_range(0, 3);
			case ($urandom_range(3))
				0: begin
					for (int i = 0; i <= nch; i++)
						send_char(plain_char());
				end
				1: begin
					send_char(CH_SQUOTE);
					for (int i = 0; i < nch; i++)
						case ($urandom_range(3))
							0: send_char(CH_SPACE);
							1: send_char(CH_BSLASH);
							2: send_char(CH_DQUOTE);
							default: send_char(plain_char());
						endcase
					send_char(CH_SQUOTE);
				end
				2: begin
					send_char(CH_DQUOTE);
					for (int i = 0; i < nch; i++)
						case ($urandom_range(4))
							0: send_char(CH_SPACE);
							1: send_char(CH_SQUOTE);
							2: begin
								send_char(CH_BSLASH);
								case ($urandom_range(2))
									0: send_char(CH_DQUOTE);
									1: send_char(CH_BSLASH);
									default: send_char(plain_char());
								endcase
							end
							default: send_char(plain_char());
						endcase
					send_char(CH_DQUOTE);
				end
				default: begin
					send_char(CH_BSLASH);
					send_char(8'($urandom_range(1, 255)));
				end
			endcase
		end
	endtask

	// Mostly well-formed lines; some carry raw noise or a malformed tail
	task automatic send_random_line();
		int nw, shape;
		nw = $urandom_range(0, 5);
		if ($urandom_range(3) == 0)
			send_char(CH_SPACE);
		for (int w = 0; w < nw; w++) begin
			send_word();
			repeat ($urandom_range(1, 2)) send_char(CH_SPACE);
		end
		shape = $urandom_range(99);
		if (shape < 12) begin
			repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
		end else if (shape < 20) begin
			case ($urandom_range(3))
				0: send_char(CH_SQUOTE);
				1: send_text("\"a\\");
				2: send_char(CH_BSLASH);
				default: begin
					send_text("\"\" ");
					send_word();
				end
			endcase
		end
		send_eol();
	endtask

	initial begin
		int target;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		items_sent = 0;
		send_idle_pct = 26;
		recv_idle_pct = 45;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: backslash pending in double quotes at end of line
		send_text("\"\\");
		send_eol();
		// Unterminated single quote; smallest nonzero and largest bytes
		send_char(CH_SQUOTE);
		send_char(8'h01);
		send_char(8'hFF);
		send_eol();
		// Empty word closes the list, so the later word is not reported
		send_text("\"\" a");
		send_eol();
		// Escaped space, escapes in double quotes, zero byte, trailing backslash
		send_text("\\ \"\\\"\\z\"");
		send_char(CH_NUL);
		send_text(" '\\'\\");
		send_eol();
		drain();

		// Three idle profiles: random lines under the first two, a capacity fill under the third
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 26 : 0;
			target = items_sent + ((phase == 2) ? 0 : 8);
			while (items_sent < target)
				send_random_line();
			// Fill the argument list past capacity
			if (phase == 2) begin
				for (int w = 0; w <= ARG_LIMIT; w++) begin
					send_char(plain_char());
					send_char(CH_SPACE);
				end
				send_eol();
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
